/* rtl/wildcard_byte_pattern_scan_unit_defines.svh */
// assertion macros shared by the wildcard byte pattern scan unit
// included by files that carry concurrent checks; no other dependencies
`ifndef WILDCARD_BYTE_PATTERN_SCAN_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wbps_pkg.sv */
// types, constants and register indexes of the wildcard byte pattern scan unit
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package wbps_pkg;

   // default number of pattern cells
   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;

   // field widths
   localparam int ADDR_WIDTH      = 48;
   localparam int OFFSET_WIDTH    = 32;
   localparam int MASK_WIDTH      = 16;
   localparam int LENGTH_WIDTH    = 5;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   // pattern bytes held in the two pattern registers
   localparam int REG_PATTERN_BYTES = 16;
   localparam int LOW_PATTERN_BYTES = 8;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WILDCARD     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET       = 3'd5;

   // per-request control broadcast to every cell
   typedef struct packed {
      logic step;   // shift the match vector by one byte
      logic clear;  // region ends, drop all partial matches
   } wbps_ctl_type;

   // one result item
   typedef struct packed {
      logic                  found;
      logic [ADDR_WIDTH-1:0] addr;
   } wbps_result_type;

endpackage

/* rtl/wbps_cell.sv */
// one position of the shift-and match row: compares the request byte with
// its pattern byte and keeps one partial-match bit; uses wbps_pkg
`timescale 1ns / 1ps

module wbps_cell import wbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  wbps_ctl_type ctl,
   input  logic [7:0]   data_byte,
   input  logic [7:0]   pattern_byte,
   input  logic         wild,
   input  logic         active,
   input  logic         prev_hit,
   output logic         hit_in,
   output logic         hit_ff
);

   // prefix through this position matches when the previous one did last byte
   assign hit_in = prev_hit & active & (wild | (data_byte == pattern_byte));

   // partial-match bit
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.clear) begin
         hit_ff <= 1'b0;
      end else if (ctl.step) begin
         hit_ff <= hit_in;
      end
   end

endmodule

/* rtl/wbps_rsp_skid.sv */
// two-entry result buffer: output register plus skid stage, so requests keep
// flowing while a result waits; uses wbps_pkg
`timescale 1ns / 1ps

module wbps_rsp_skid import wbps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  wbps_result_type push_data,
   output logic            has_room,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output wbps_result_type rsp_data
);

   logic            out_valid_ff, out_valid_in;
   wbps_result_type out_data_ff, out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   wbps_result_type skid_data_ff, skid_data_in;
   logic            out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign has_room  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // next state of both entries, oldest result always in the output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* rtl/wildcard_byte_pattern_scan_unit.sv */
// A result is registered into the result buffer's output register, or into its skid entry while rsp stalls.
// One byte per cycle while the skid entry is free; each shift-and step is one pass through the cell
// row, and a two-entry result buffer keeps requests flowing while a result waits.
// Reset (synchronous, active high) clears match bits, byte counter, reported flag
// and the result buffer; registers return to pattern length 1, all others zero.
// Top level; uses wbps_pkg, wbps_cell, wbps_rsp_skid and the assertion macros.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_unit_defines.svh"

module wildcard_byte_pattern_scan_unit import wbps_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tlast,   // region_end
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ADDR_WIDTH-1:0]      rsp_tdata,   // [47:0] match_address
   output logic                       rsp_tuser,   // found
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);

   // registers
   logic [CSR_DATA_WIDTH-1:0] pat_low_ff;
   logic [CSR_DATA_WIDTH-1:0] pat_high_ff;
   logic [MASK_WIDTH-1:0]     wild_ff;
   logic [LENGTH_WIDTH-1:0]   len_ff;
   logic [ADDR_WIDTH-1:0]     base_ff;
   logic [OFFSET_WIDTH-1:0]   offset_ff;

   // scan state
   logic [ADDR_WIDTH-1:0]     byte_idx_ff, byte_idx_in;
   logic                      reported_ff, reported_in;

   logic                      req_take;
   logic [IDX_W-1:0]          lenm1;
   wbps_ctl_type              ctl;
   logic [MAX_PATTERN_BYTES-1:0] hit_next;
   logic [MAX_PATTERN_BYTES-1:0] hit_vec;
   logic                      full_hit;
   logic                      produce;
   wbps_result_type           result;
   wbps_result_type           rsp_data;
   logic                      has_room;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         wild_ff     <= '0;
         len_ff      <= LENGTH_WIDTH'(1);
         base_ff     <= '0;
         offset_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_WILDCARD:     wild_ff     <= csr_data[MASK_WIDTH-1:0];
            CSR_LENGTH:       len_ff      <= csr_data[LENGTH_WIDTH-1:0];
            CSR_BASE:         base_ff     <= csr_data[ADDR_WIDTH-1:0];
            CSR_OFFSET:       offset_ff   <= csr_data[OFFSET_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // effective length minus one: zero length acts as one, long lengths saturate
   always_comb begin
      if (32'(len_ff) > MAX_PATTERN_BYTES) begin
         lenm1 = IDX_W'(MAX_PATTERN_BYTES - 1);
      end else if (len_ff == '0) begin
         lenm1 = '0;
      end else begin
         lenm1 = IDX_W'(len_ff - LENGTH_WIDTH'(1));
      end
   end

   assign req_tready = has_room;
   assign req_take   = req_tvalid && req_tready;

   assign ctl.step  = req_take && !reported_ff;
   assign ctl.clear = req_take && req_tlast;

   // row of match cells, each but the first fed by the stored bit of its left neighbor; the first is fed a one
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [7:0] pbyte;
      logic       pwild;
      logic       prev;

      if (i < LOW_PATTERN_BYTES) begin : g_low
         assign pbyte = pat_low_ff[8*i +: 8];
         assign pwild = wild_ff[i];
      end else if (i < REG_PATTERN_BYTES) begin : g_high
         assign pbyte = pat_high_ff[8*(i-LOW_PATTERN_BYTES) +: 8];
         assign pwild = wild_ff[i];
      end else begin : g_none
         assign pbyte = 8'h00;
         assign pwild = 1'b0;
      end

      if (i == 0) begin : g_first
         assign prev = 1'b1;
      end else begin : g_rest
         assign prev = hit_vec[i-1];
      end

      wbps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .data_byte    (req_tdata),
         .pattern_byte (pbyte),
         .wild         (pwild),
         .active       (IDX_W'(i) <= lenm1),
         .prev_hit     (prev),
         .hit_in       (hit_next[i]),
         .hit_ff       (hit_vec[i])
      );
   end

   // full match ends at this byte
   assign full_hit = hit_next[lenm1];
   assign produce  = req_take && !reported_ff && (full_hit || req_tlast);

   // result: base + (index - (length - 1)) + offset, or not found
   always_comb begin
      result.found = full_hit;
      if (full_hit) begin
         result.addr = base_ff + byte_idx_ff - ADDR_WIDTH'(lenm1)
                       + ADDR_WIDTH'(offset_ff);
      end else begin
         result.addr = '0;
      end
   end

   // byte counter and reported flag
   always_comb begin
      byte_idx_in = byte_idx_ff;
      reported_in = reported_ff;
      if (req_take) begin
         if (req_tlast) begin
            byte_idx_in = '0;
            reported_in = 1'b0;
         end else begin
            byte_idx_in = byte_idx_ff + ADDR_WIDTH'(1);
            reported_in = reported_ff || full_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= '0;
         reported_ff <= 1'b0;
      end else begin
         byte_idx_ff <= byte_idx_in;
         reported_ff <= reported_in;
      end
   end

   // result buffer
   wbps_rsp_skid u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (produce),
      .push_data (result),
      .has_room  (has_room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data.addr;
   assign rsp_tuser = rsp_data.found;

   // checks
   `WBPS_ASSERT_NOW(a_not_found_zero, clock, reset, produce && !result.found, result.addr == '0, "not-found result carries an address")
   `WBPS_ASSERT_NOW(a_room_means_flow, clock, reset, !has_room, rsp_tvalid, "skid entry full while output register empty")
   `WBPS_ASSERT_NEXT(a_region_restart, clock, reset, req_take && req_tlast, byte_idx_ff == '0 && !reported_ff && hit_vec == '0, "scan state not cleared after region end")
   `WBPS_ASSERT_NEXT(a_one_report, clock, reset, req_take && full_hit && !reported_ff && !req_tlast, reported_ff, "match not recorded as reported")

endmodule
